[src/leb_pkg.sv]
// leb_pkg: shared types and constants of the line edit buffer
`default_nettype none
package leb_pkg;

  // input op codes
  localparam logic [3:0] OP_CHAR      = 4'd0;
  localparam logic [3:0] OP_LEFT      = 4'd1;
  localparam logic [3:0] OP_RIGHT     = 4'd2;
  localparam logic [3:0] OP_HOME      = 4'd3;
  localparam logic [3:0] OP_END       = 4'd4;
  localparam logic [3:0] OP_BACKSPACE = 4'd5;
  localparam logic [3:0] OP_DELETE    = 4'd6;
  localparam logic [3:0] OP_TAB       = 4'd7;
  localparam logic [3:0] OP_ENTER     = 4'd8;

  localparam logic [7:0] TAB_BYTE   = 8'd9;
  localparam logic [7:0] PRINT_LO   = 8'd32;
  localparam logic [7:0] PRINT_HI   = 8'd126;

  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CNT_W     = 7;
  localparam logic [CFG_W-1:0] MAX_OUT_RESET = 7'd64;

  typedef enum logic [2:0] {
    CMD_INSERT,
    CMD_LEFT,
    CMD_RIGHT,
    CMD_HOME,
    CMD_END,
    CMD_BACKSPACE,
    CMD_DELETE,
    CMD_ENTER
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage
`default_nettype wire

[src/leb_front.sv]
// leb_front: accepts key transactions and turns them into edit commands
`default_nettype none
module leb_front
  import leb_pkg::*;
(
  input  wire logic       start,
  input  wire logic       busy,
  input  wire logic [3:0] in_op,
  input  wire logic [7:0] in_key_char,
  output logic            push,
  output cmd_t            push_cmd
);

  logic keep;

  always_comb begin
    keep          = 1'b1;
    push_cmd.kind = CMD_INSERT;
    push_cmd.data = in_key_char;
    unique case (in_op)
      OP_CHAR: begin
        keep = (in_key_char >= PRINT_LO) && (in_key_char <= PRINT_HI);
      end
      OP_LEFT:      push_cmd.kind = CMD_LEFT;
      OP_RIGHT:     push_cmd.kind = CMD_RIGHT;
      OP_HOME:      push_cmd.kind = CMD_HOME;
      OP_END:       push_cmd.kind = CMD_END;
      OP_BACKSPACE: push_cmd.kind = CMD_BACKSPACE;
      OP_DELETE:    push_cmd.kind = CMD_DELETE;
      OP_TAB:       push_cmd.data = TAB_BYTE;
      OP_ENTER:     push_cmd.kind = CMD_ENTER;
      default:      keep = 1'b0;
    endcase
  end

  // ignored keys are accepted but never queued
  assign push = start && !busy && keep;

endmodule
`default_nettype wire

[src/leb_queue.sv]
// leb_queue: two entry command queue between front and back
`default_nettype none
module leb_queue
  import leb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      full,
  output q_head_t   head
);

  cmd_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head.valid = (cnt_r != 2'd0);
  assign head.cmd   = ent_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

[src/leb_back.sv]
// leb_back: line store, cursor and length; executes edit commands
`default_nettype none
module leb_back
  import leb_pkg::*;
#(
  parameter int unsigned LINE_CAP = 63
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire q_head_t          head,
  output logic                  pop,
  input  wire logic [CFG_W-1:0] max_line_out,
  output logic                  out_strobe,
  output logic [7:0]            out_char,
  output logic                  out_last,
  output logic [CNT_W-1:0]      out_count
);

  localparam int unsigned POS_W  = $clog2(LINE_CAP + 1);
  localparam int unsigned ADDR_W = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHR,
    ST_INS_DRAIN,
    ST_INS_BYTE,
    ST_DEL,
    ST_DEL_DRAIN,
    ST_EMIT,
    ST_EMIT_DRAIN,
    ST_TERM
  } state_t;

  state_t             state_r, state_nxt;
  logic [POS_W-1:0]   cur_r, cur_nxt;
  logic [POS_W-1:0]   len_r, len_nxt;
  logic [ADDR_W-1:0]  p_r, p_nxt;
  logic [ADDR_W-1:0]  e_r, e_nxt;
  logic [ADDR_W-1:0]  pdst_r, pdst_nxt;
  logic               pend_r, pend_nxt;
  logic               epend_r, epend_nxt;
  logic [7:0]         b_r, b_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic [7:0]         mem [LINE_CAP];
  logic [7:0]         rdata_r;
  logic               rd_en;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [7:0]         wdata;

  logic [POS_W-1:0]   cur_p1, cur_m1, len_m1;
  logic [CNT_W-1:0]   limit, len_ext, n_out, n_m1;

  assign cur_p1  = cur_r + 1'b1;
  assign cur_m1  = cur_r - 1'b1;
  assign len_m1  = len_r - 1'b1;
  assign len_ext = CNT_W'(len_r);
  assign limit   = (max_line_out == '0) ? '0 : max_line_out - 1'b1;
  assign n_out   = (len_ext < limit) ? len_ext : limit;
  assign n_m1    = n_out - 1'b1;

  assign pop   = (state_r == ST_IDLE) && head.valid;
  assign rd_en = (state_r == ST_SHR) || (state_r == ST_DEL) || (state_r == ST_EMIT);

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    len_nxt   = len_r;
    p_nxt     = p_r;
    e_nxt     = e_r;
    pdst_nxt  = pdst_r;
    pend_nxt  = 1'b0;
    epend_nxt = 1'b0;
    b_nxt     = b_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          unique case (head.cmd.kind)
            CMD_INSERT: begin
              if (len_r != POS_W'(LINE_CAP)) begin
                cur_nxt = cur_p1;
                len_nxt = len_r + 1'b1;
                b_nxt   = head.cmd.data;
                e_nxt   = cur_r[ADDR_W-1:0];
                if (cur_r == len_r) begin
                  state_nxt = ST_INS_BYTE;
                end else begin
                  p_nxt     = len_m1[ADDR_W-1:0];
                  state_nxt = ST_SHR;
                end
              end
            end
            CMD_LEFT: begin
              if (cur_r != '0) cur_nxt = cur_m1;
            end
            CMD_RIGHT: begin
              if (cur_r < len_r) cur_nxt = cur_p1;
            end
            CMD_HOME: cur_nxt = '0;
            CMD_END:  cur_nxt = len_r;
            CMD_BACKSPACE: begin
              // remove the byte at cursor - 1; tail starts at the old cursor
              if (cur_r != '0) begin
                cur_nxt = cur_m1;
                len_nxt = len_m1;
                if (cur_r < len_r) begin
                  p_nxt     = cur_r[ADDR_W-1:0];
                  e_nxt     = len_m1[ADDR_W-1:0];
                  state_nxt = ST_DEL;
                end
              end
            end
            CMD_DELETE: begin
              if (cur_r < len_r) begin
                len_nxt = len_m1;
                if (cur_p1 < len_r) begin
                  p_nxt     = cur_p1[ADDR_W-1:0];
                  e_nxt     = len_m1[ADDR_W-1:0];
                  state_nxt = ST_DEL;
                end
              end
            end
            CMD_ENTER: begin
              cur_nxt = '0;
              len_nxt = '0;
              cnt_nxt = n_out + 1'b1;
              if (n_out == '0) begin
                state_nxt = ST_TERM;
              end else begin
                p_nxt     = '0;
                e_nxt     = n_m1[ADDR_W-1:0];
                state_nxt = ST_EMIT;
              end
            end
          endcase
        end
      end
      ST_SHR: begin
        // move store[p] up to store[p+1], walking down to the cursor
        pend_nxt = 1'b1;
        pdst_nxt = p_r + ADDR_W'(1);
        if (p_r == e_r) state_nxt = ST_INS_DRAIN;
        else            p_nxt     = p_r - ADDR_W'(1);
      end
      ST_INS_DRAIN: state_nxt = ST_INS_BYTE;
      ST_INS_BYTE:  state_nxt = ST_IDLE;
      ST_DEL: begin
        pend_nxt = 1'b1;
        pdst_nxt = p_r - ADDR_W'(1);
        if (p_r == e_r) state_nxt = ST_DEL_DRAIN;
        else            p_nxt     = p_r + ADDR_W'(1);
      end
      ST_DEL_DRAIN: state_nxt = ST_IDLE;
      ST_EMIT: begin
        epend_nxt = 1'b1;
        if (p_r == e_r) state_nxt = ST_EMIT_DRAIN;
        else            p_nxt     = p_r + ADDR_W'(1);
      end
      ST_EMIT_DRAIN: state_nxt = ST_TERM;
      ST_TERM:       state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cur_r   <= '0;
      len_r   <= '0;
      pend_r  <= 1'b0;
      epend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      len_r   <= len_nxt;
      pend_r  <= pend_nxt;
      epend_r <= epend_nxt;
    end
    p_r    <= p_nxt;
    e_r    <= e_nxt;
    pdst_r <= pdst_nxt;
    b_r    <= b_nxt;
    cnt_r  <= cnt_nxt;
  end

  // one write port: pending moves, or the inserted byte
  always_comb begin
    we    = 1'b0;
    waddr = e_r;
    wdata = b_r;
    if (pend_r) begin
      we    = 1'b1;
      waddr = pdst_r;
      wdata = rdata_r;
    end else if (state_r == ST_INS_BYTE) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[p_r];
    end
  end

  assign out_strobe = epend_r || (state_r == ST_TERM);
  assign out_last   = (state_r == ST_TERM);
  assign out_char   = (state_r == ST_TERM) ? 8'd0 : rdata_r;
  assign out_count  = (state_r == ST_TERM) ? cnt_r : '0;

endmodule
`default_nettype wire

[src/line_edit_buffer_core.sv]
// line_edit_buffer_core: top level of the terminal line edit buffer
`default_nettype none
// terminal line editor, one decoded key per transaction. the front decodes the
// key and drops ignored ones (non-printable chars, unused op codes); the rest
// enter a two entry queue, and start is taken whenever busy is low, i.e. while
// the queue has room. the back runs one command at a time against a LINE_CAP
// byte line store with one write and one registered read port. cursor moves,
// and inserts or deletes at the end of the line, move no stored bytes; an
// insert or a delete in the middle shifts the tail, one stored byte moved per
// cycle. enter emits n bytes as one byte transaction per cycle on out_strobe,
// back to back, then the terminator with out_last set and out_count
// = n + 1. results cannot be held off: each stands on the ports for exactly one
// cycle. max_line_out is written through cfg_valid/cfg_ready (always ready)
// and should only change while no enter is queued or running. no clearing pass
// after reset: stored bytes are read only after they were written.
module line_edit_buffer_core
  import leb_pkg::*;
#(
  parameter int unsigned LINE_CAP = 63
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // key transactions
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [3:0]       in_op,
  input  wire logic [7:0]       in_key_char,
  // emitted line
  output logic                  out_strobe,
  output logic [7:0]            out_char,
  output logic                  out_last,
  output logic [CNT_W-1:0]      out_count,
  // destination size register
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data
);

  logic             push;
  cmd_t             push_cmd;
  logic             pop;
  logic             q_full;
  q_head_t          head;
  logic [CFG_W-1:0] max_out_r;

  // queue full is the only back-pressure on the key side
  assign busy      = q_full;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_out_r <= MAX_OUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_out_r <= cfg_data;
    end
  end

  // decode and filter keys
  leb_front u_front (
    .start       (start),
    .busy        (q_full),
    .in_op       (in_op),
    .in_key_char (in_key_char),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // decouples key intake from the slow edit / emit engine
  leb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .head     (head)
  );

  // line store, cursor and length
  leb_back #(
    .LINE_CAP (LINE_CAP)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .pop          (pop),
    .max_line_out (max_out_r),
    .out_strobe   (out_strobe),
    .out_char     (out_char),
    .out_last     (out_last),
    .out_count    (out_count)
  );

  // a terminator closes the line: the engine goes back to idle
  a_term_then_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |=> !out_strobe)
    else $error("result transaction right after terminator");

  // byte transactions of a line are contiguous up to the terminator
  a_bytes_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |=> out_strobe)
    else $error("gap inside emitted line");

  // terminator count is at least one and never beyond the store size plus one
  a_term_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> (out_count != '0) && (out_count <= CNT_W'(LINE_CAP + 1)))
    else $error("terminator count out of range");

  // nothing comes out in the first cycle after reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_strobe)
    else $error("result transaction right after reset");

endmodule
`default_nettype wire

[tb/tb_line_edit_buffer_core.sv]
// tb_line_edit_buffer_core: self-checking testbench of the line edit buffer core
module tb_line_edit_buffer_core;
  import leb_pkg::*;

  localparam int LINE_CAP       = 63;
  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 11;
  // an insert in the middle moves up to 62 bytes; two commands may be queued
  localparam int SETTLE_CYCLES  = 200;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_EDITS   = 280;
  localparam int MAX_REPORTS    = 30;
  localparam int N_DIR          = 23;
  localparam int N_FIXED_SIZES  = 7;

  // op codes the block must ignore
  localparam logic [3:0] OP_UNUSED_LO = 4'd9;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  // one emitted line byte or the terminator
  typedef struct packed {
    logic [7:0]       ch;
    logic             last;
    logic [CNT_W-1:0] cnt;
  } line_byte_t;

  // one directed key; cnt is the terminator count when typed is set
  typedef struct packed {
    logic [3:0]       op;
    logic [7:0]       ch;
    logic             typed;
    logic [CNT_W-1:0] cnt;
  } key_row_t;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             start       = 1'b0;
  logic [3:0]       in_op       = '0;
  logic [7:0]       in_key_char = '0;
  logic             cfg_valid   = 1'b0;
  logic [CFG_W-1:0] cfg_data    = '0;
  logic             busy;
  logic             out_strobe;
  logic [7:0]       out_char;
  logic             out_last;
  logic [CNT_W-1:0] out_count;
  logic             cfg_ready;

  // expected line state
  logic [7:0]       line_mem [LINE_CAP];
  logic [5:0]       cur_pos   = '0;
  logic [5:0]       line_len  = '0;
  logic [CFG_W-1:0] dest_size = MAX_OUT_RESET;

  line_byte_t pending_bytes[$];
  key_row_t   dir_rows [N_DIR];
  logic [CFG_W-1:0] fixed_sizes [N_FIXED_SIZES];

  int  mismatches  = 0;
  int  keys_sent   = 0;
  int  edits_sent  = 0;
  int  bytes_seen  = 0;
  int  lines_seen  = 0;
  int  sizes_tried = 0;
  int  idle_cycles = 0;
  bit  no_gaps     = 1'b0;

  line_edit_buffer_core #(.LINE_CAP(LINE_CAP)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_op      (in_op),
    .in_key_char(in_key_char),
    .out_strobe (out_strobe),
    .out_char   (out_char),
    .out_last   (out_last),
    .out_count  (out_count),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // line model
  // ---------------------------------------------------------------------------

  // insert at the cursor, tail moves right; dropped on a full line
  task automatic insert_byte(input logic [7:0] b);
    int i;
    if (line_len < LINE_CAP) begin
      for (i = line_len; i > cur_pos; i--) line_mem[i] = line_mem[i - 1];
      line_mem[cur_pos] = b;
      cur_pos++;
      line_len++;
    end
  endtask

  // remove the byte under the cursor, tail moves left
  task automatic drop_byte();
    int i;
    if (cur_pos < line_len) begin
      for (i = cur_pos; i + 1 < line_len; i++) line_mem[i] = line_mem[i + 1];
      line_len--;
    end
  endtask

  // apply one key, queue the line bytes an enter emits
  task automatic edit_line(input logic [3:0] op, input logic [7:0] ch);
    int i;
    int n;
    int limit;
    case (op)
      OP_CHAR:      if (ch >= PRINT_LO && ch <= PRINT_HI) insert_byte(ch);
      OP_LEFT:      if (cur_pos != 0) cur_pos--;
      OP_RIGHT:     if (cur_pos < line_len) cur_pos++;
      OP_HOME:      cur_pos = '0;
      OP_END:       cur_pos = line_len;
      OP_BACKSPACE: if (cur_pos != 0) begin
        cur_pos--;
        drop_byte();
      end
      OP_DELETE:    drop_byte();
      OP_TAB:       insert_byte(TAB_BYTE);
      OP_ENTER: begin
        // size 0 behaves like 1: terminator only
        limit = (dest_size == 0) ? 0 : int'(dest_size) - 1;
        n = (int'(line_len) < limit) ? int'(line_len) : limit;
        for (i = 0; i < n; i++) pending_bytes.push_back({line_mem[i], 1'b0, CNT_W'(0)});
        pending_bytes.push_back({8'h00, 1'b1, CNT_W'(n + 1)});
        cur_pos  = '0;
        line_len = '0;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one key transaction; called right after a rising edge
  task automatic send_key(input logic [3:0] op, input logic [7:0] ch,
                          input logic typed, input logic [CNT_W-1:0] typed_cnt);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_op       <= op;
    in_key_char <= ch;
    @(posedge clk);
    while (busy) @(posedge clk);
    keys_sent++;
    if (op <= OP_ENTER && !(op == OP_CHAR && (ch < PRINT_LO || ch > PRINT_HI)))
      edits_sent++;
    edit_line(op, ch);
    if (typed && op == OP_ENTER) pending_bytes[pending_bytes.size() - 1].cnt = typed_cnt;
  endtask

  // printable text with an occasional tab
  task automatic type_text(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) send_key(OP_TAB, 8'($urandom), 1'b0, '0);
      else send_key(OP_CHAR, 8'($urandom_range(PRINT_LO, PRINT_HI)), 1'b0, '0);
    end
  endtask

  // cursor moves, deletions, stray inserts and ignored bytes
  task automatic edit_keys(input int n);
    int k;
    logic [7:0] junk;
    for (k = 0; k < n; k++) begin
      junk = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, PRINT_LO - 1))
                                        : 8'($urandom_range(PRINT_HI + 1, 255));
      case ($urandom_range(0, 9))
        0, 1:    send_key(OP_LEFT, 8'($urandom), 1'b0, '0);
        2:       send_key(OP_RIGHT, 8'($urandom), 1'b0, '0);
        3:       send_key(OP_HOME, 8'($urandom), 1'b0, '0);
        4:       send_key(OP_END, 8'($urandom), 1'b0, '0);
        5:       send_key(OP_BACKSPACE, 8'($urandom), 1'b0, '0);
        6:       send_key(OP_DELETE, 8'($urandom), 1'b0, '0);
        7:       send_key(OP_CHAR, junk, 1'b0, '0);
        default: type_text(1);
      endcase
    end
  endtask

  // random line editing sessions until enough keys did something
  task automatic run_phase(input int target);
    int goal;
    int kind;
    int k;
    goal = edits_sent + target;
    while (edits_sent < goal) begin
      kind = $urandom_range(0, 15);
      if (kind < 2) begin
        // fill to the brim, push past it, then emit
        type_text($urandom_range(60, 68));
        if ($urandom_range(0, 1) == 0) edit_keys($urandom_range(1, 4));
        type_text($urandom_range(0, 3));
        send_key(OP_ENTER, 8'($urandom), 1'b0, '0);
      end else if (kind < 4) begin
        // any op code, any byte
        for (k = $urandom_range(1, 4); k > 0; k--)
          send_key(4'($urandom_range(0, 15)), 8'($urandom), 1'b0, '0);
      end else begin
        type_text($urandom_range(1, 12));
        edit_keys($urandom_range(0, 8));
        if ($urandom_range(0, 9) != 0) send_key(OP_ENTER, 8'($urandom), 1'b0, '0);
      end
    end
  endtask

  // let the queue run dry, then give a running shift time to finish
  task automatic drain_and_settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dest_size(input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    dest_size = v;
    sizes_tried++;
  endtask

  // ---------------------------------------------------------------------------
  // result check: every strobe is one line byte or the terminator
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_line_out
    line_byte_t want;
    if (rst_n && out_strobe) begin
      if (out_last) lines_seen++;
      else bytes_seen++;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected line transaction char=%0d last=%0b count=%0d",
                   $time, out_char, out_last, out_count);
      end else begin
        want = pending_bytes.pop_front();
        if (out_char !== want.ch || out_last !== want.last || out_count !== want.cnt) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: line mismatch expected char=%0d last=%0b count=%0d, %s%0d %0b %0d",
                     $time, want.ch, want.last, want.cnt, "actual char/last/count=",
                     out_char, out_last, out_count);
        end
      end
    end
  end

  // stop a hung run: no key, line or register transaction for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int r;
    logic [CFG_W-1:0] sz;

    // directed keys at reset size: edges of the printable range, every op,
    // cursor at both edges, backspace at start, delete at end, unused codes
    dir_rows = '{
      {OP_ENTER,     8'h00,            1'b1, CNT_W'(1)},  // empty line after reset
      {OP_CHAR,      PRINT_LO - 8'd1,  1'b0, CNT_W'(0)},  // below printable, ignored
      {OP_CHAR,      PRINT_LO,         1'b0, CNT_W'(0)},
      {OP_CHAR,      PRINT_HI,         1'b0, CNT_W'(0)},
      {OP_CHAR,      PRINT_HI + 8'd1,  1'b0, CNT_W'(0)},  // above printable, ignored
      {OP_CHAR,      8'hFF,            1'b0, CNT_W'(0)},
      {OP_CHAR,      8'h00,            1'b0, CNT_W'(0)},
      {OP_TAB,       8'hA5,            1'b0, CNT_W'(0)},  // key byte does not matter
      {OP_LEFT,      8'h00,            1'b0, CNT_W'(0)},
      {OP_LEFT,      8'h00,            1'b0, CNT_W'(0)},
      {OP_CHAR,      8'h41,            1'b0, CNT_W'(0)},  // insert mid line
      {OP_HOME,      8'h00,            1'b0, CNT_W'(0)},
      {OP_LEFT,      8'h00,            1'b0, CNT_W'(0)},  // already at start
      {OP_BACKSPACE, 8'h00,            1'b0, CNT_W'(0)},  // nothing before cursor
      {OP_DELETE,    8'h00,            1'b0, CNT_W'(0)},
      {OP_END,       8'h00,            1'b0, CNT_W'(0)},
      {OP_RIGHT,     8'h00,            1'b0, CNT_W'(0)},  // already at end
      {OP_DELETE,    8'h00,            1'b0, CNT_W'(0)},  // nothing under cursor
      {OP_BACKSPACE, 8'h00,            1'b0, CNT_W'(0)},
      {OP_UNUSED_LO, 8'h41,            1'b0, CNT_W'(0)},
      {OP_UNUSED_HI, 8'hFF,            1'b0, CNT_W'(0)},
      {OP_ENTER,     8'h00,            1'b0, CNT_W'(0)},
      {OP_ENTER,     8'h00,            1'b1, CNT_W'(1)}   // line was just emptied
    };
    // zero acts as one, largest field value passes the whole line
    fixed_sizes = '{7'd0, 7'd1, 7'd2, 7'd127, 7'd64, 7'd63, 7'd17};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < N_DIR; r++)
      send_key(dir_rows[r].op, dir_rows[r].ch, dir_rows[r].typed, dir_rows[r].cnt);
    drain_and_settle();

    // random sessions, one destination size per phase
    r = 0;
    while (edits_sent < RANDOM_EDITS + N_DIR) begin
      sz = (r < N_FIXED_SIZES) ? fixed_sizes[r] : CFG_W'($urandom_range(0, 127));
      write_dest_size(sz);
      no_gaps = ($urandom_range(0, 3) == 0);
      run_phase($urandom_range(35, 55));
      drain_and_settle();
      r++;
    end

    $display("run covered %0d key transactions (%0d took effect) over %0d destination sizes",
             keys_sent, edits_sent, sizes_tried);
    $display("checked %0d emitted lines with %0d bytes, %0d mismatches",
             lines_seen, bytes_seen, mismatches);
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
src/leb_pkg.sv
src/leb_front.sv
src/leb_queue.sv
src/leb_back.sv
src/line_edit_buffer_core.sv
tb/tb_line_edit_buffer_core.sv
